/* rtl/core/bpc_pkg.sv */
// ----------------------------------------------------------------------------
// Barometric compensation package
// Shared types, codes and the compensation microprogram for the block.
// ----------------------------------------------------------------------------
package bpc_pkg;

   localparam int PC_W = 6;
   localparam logic [PC_W-1:0] PC_TEMP  = 6'd0;
   localparam logic [PC_W-1:0] PC_PRESS = 6'd16;

   localparam int CNT_W = 7;
   localparam logic [CNT_W-1:0] MUL_LAST = 7'd2;
   localparam logic [CNT_W-1:0] DIV_LAST = 7'd65;

   localparam int SHAMT_W = 6;
   localparam int IMM_W   = 21;

   localparam logic [2:0] CSR_TEMP_COEF_1    = 3'd0;
   localparam logic [2:0] CSR_TEMP_COEF_2    = 3'd1;
   localparam logic [2:0] CSR_TEMP_COEF_3    = 3'd2;
   localparam logic [2:0] CSR_PRESS_COEF_1   = 3'd3;
   localparam logic [2:0] CSR_PRESS_COEF_2_3 = 3'd4;
   localparam logic [2:0] CSR_PRESS_COEF_4_5 = 3'd5;
   localparam logic [2:0] CSR_PRESS_COEF_6_7 = 3'd6;
   localparam logic [2:0] CSR_PRESS_COEF_8_9 = 3'd7;

   localparam logic KIND_TEMP  = 1'b0;
   localparam logic KIND_PRESS = 1'b1;

   typedef struct packed {
      logic        cmd;
      logic [19:0] raw_sample;
   } bpc_req_type;

   typedef struct packed {
      logic               kind;
      logic signed [31:0] temperature_centi;
      logic [31:0]        pressure_q24_8;
      logic               divide_by_zero;
   } bpc_rsp_type;

   typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_EMIT} bpc_state_type;

   typedef enum logic [2:0] {
      OP_NOP, OP_ADD, OP_SUB, OP_SHL, OP_ASR, OP_MUL, OP_DIV, OP_CHKZ
   } bpc_op_type;

   typedef enum logic [1:0] {REG_R0, REG_R1, REG_R2, REG_R3} bpc_reg_type;

   typedef enum logic [4:0] {
      SRC_R0, SRC_R1, SRC_R2, SRC_R3, SRC_ADC, SRC_FINE, SRC_IMM,
      SRC_T1, SRC_T2, SRC_T3,
      SRC_P1, SRC_P2, SRC_P3, SRC_P4, SRC_P5, SRC_P6, SRC_P7, SRC_P8, SRC_P9
   } bpc_src_type;

   typedef struct packed {
      bpc_op_type           op;
      bpc_reg_type          dst;
      bpc_src_type          src_a;
      bpc_src_type          src_b;
      logic [SHAMT_W-1:0]   shamt;
      logic [IMM_W-1:0]     imm;
      logic                 w32;
      logic                 fine_wr;
      logic                 last;
   } bpc_uop_type;

   typedef struct packed {
      logic        go;
      bpc_uop_type uop;
      logic        load_in;
      logic        out_wr;
      logic        out_kind;
      logic        out_dz;
   } bpc_cmd_type;

   typedef struct packed {
      logic done;
      logic div_zero;
   } bpc_stat_type;

   function automatic bpc_uop_type mk(input bpc_op_type op, input bpc_reg_type dst,
                                      input bpc_src_type a, input bpc_src_type b,
                                      input logic [SHAMT_W-1:0] sh,
                                      input logic [IMM_W-1:0] imm, input logic w32,
                                      input logic fine_wr, input logic last);
      bpc_uop_type u;
      u.op      = op;
      u.dst     = dst;
      u.src_a   = a;
      u.src_b   = b;
      u.shamt   = sh;
      u.imm     = imm;
      u.w32     = w32;
      u.fine_wr = fine_wr;
      u.last    = last;
      return u;
   endfunction

   // Temperature steps run on 32-bit wrapped values; pressure steps on 64 bits.
   function automatic bpc_uop_type uop_rom(input logic [PC_W-1:0] pc);
      bpc_uop_type u;
      unique case (pc)
         6'd0:  u = mk(OP_ASR, REG_R0, SRC_ADC, SRC_ADC, 6'd3, '0, 1'b1, 1'b0, 1'b0);
         6'd1:  u = mk(OP_SHL, REG_R1, SRC_T1, SRC_T1, 6'd1, '0, 1'b1, 1'b0, 1'b0);
         6'd2:  u = mk(OP_SUB, REG_R0, SRC_R0, SRC_R1, 6'd0, '0, 1'b1, 1'b0, 1'b0);
         6'd3:  u = mk(OP_MUL, REG_R0, SRC_R0, SRC_T2, 6'd0, '0, 1'b1, 1'b0, 1'b0);
         6'd4:  u = mk(OP_ASR, REG_R0, SRC_R0, SRC_R0, 6'd11, '0, 1'b1, 1'b0, 1'b0);
         6'd5:  u = mk(OP_ASR, REG_R1, SRC_ADC, SRC_ADC, 6'd4, '0, 1'b1, 1'b0, 1'b0);
         6'd6:  u = mk(OP_SUB, REG_R1, SRC_R1, SRC_T1, 6'd0, '0, 1'b1, 1'b0, 1'b0);
         6'd7:  u = mk(OP_MUL, REG_R1, SRC_R1, SRC_R1, 6'd0, '0, 1'b1, 1'b0, 1'b0);
         6'd8:  u = mk(OP_ASR, REG_R1, SRC_R1, SRC_R1, 6'd12, '0, 1'b1, 1'b0, 1'b0);
         6'd9:  u = mk(OP_MUL, REG_R1, SRC_R1, SRC_T3, 6'd0, '0, 1'b1, 1'b0, 1'b0);
         6'd10: u = mk(OP_ASR, REG_R1, SRC_R1, SRC_R1, 6'd14, '0, 1'b1, 1'b0, 1'b0);
         6'd11: u = mk(OP_ADD, REG_R0, SRC_R0, SRC_R1, 6'd0, '0, 1'b1, 1'b1, 1'b0);
         6'd12: u = mk(OP_MUL, REG_R0, SRC_R0, SRC_IMM, 6'd0, 21'd5, 1'b1, 1'b0, 1'b0);
         6'd13: u = mk(OP_ADD, REG_R0, SRC_R0, SRC_IMM, 6'd0, 21'd128, 1'b1, 1'b0, 1'b0);
         6'd14: u = mk(OP_ASR, REG_R0, SRC_R0, SRC_R0, 6'd8, '0, 1'b1, 1'b0, 1'b1);
         6'd16: u = mk(OP_SUB, REG_R0, SRC_FINE, SRC_IMM, 6'd0, 21'd128000, 1'b0, 1'b0, 1'b0);
         6'd17: u = mk(OP_MUL, REG_R1, SRC_R0, SRC_R0, 6'd0, '0, 1'b0, 1'b0, 1'b0);
         6'd18: u = mk(OP_MUL, REG_R2, SRC_R1, SRC_P6, 6'd0, '0, 1'b0, 1'b0, 1'b0);
         6'd19: u = mk(OP_MUL, REG_R3, SRC_R0, SRC_P5, 6'd0, '0, 1'b0, 1'b0, 1'b0);
         6'd20: u = mk(OP_SHL, REG_R3, SRC_R3, SRC_R3, 6'd17, '0, 1'b0, 1'b0, 1'b0);
         6'd21: u = mk(OP_ADD, REG_R2, SRC_R2, SRC_R3, 6'd0, '0, 1'b0, 1'b0, 1'b0);
         6'd22: u = mk(OP_SHL, REG_R3, SRC_P4, SRC_P4, 6'd35, '0, 1'b0, 1'b0, 1'b0);
         6'd23: u = mk(OP_ADD, REG_R2, SRC_R2, SRC_R3, 6'd0, '0, 1'b0, 1'b0, 1'b0);
         6'd24: u = mk(OP_MUL, REG_R1, SRC_R1, SRC_P3, 6'd0, '0, 1'b0, 1'b0, 1'b0);
         6'd25: u = mk(OP_ASR, REG_R1, SRC_R1, SRC_R1, 6'd8, '0, 1'b0, 1'b0, 1'b0);
         6'd26: u = mk(OP_MUL, REG_R3, SRC_R0, SRC_P2, 6'd0, '0, 1'b0, 1'b0, 1'b0);
         6'd27: u = mk(OP_SHL, REG_R3, SRC_R3, SRC_R3, 6'd12, '0, 1'b0, 1'b0, 1'b0);
         6'd28: u = mk(OP_ADD, REG_R1, SRC_R1, SRC_R3, 6'd0, '0, 1'b0, 1'b0, 1'b0);
         6'd29: u = mk(OP_SHL, REG_R3, SRC_IMM, SRC_IMM, 6'd47, 21'd1, 1'b0, 1'b0, 1'b0);
         6'd30: u = mk(OP_ADD, REG_R1, SRC_R1, SRC_R3, 6'd0, '0, 1'b0, 1'b0, 1'b0);
         6'd31: u = mk(OP_MUL, REG_R1, SRC_R1, SRC_P1, 6'd0, '0, 1'b0, 1'b0, 1'b0);
         6'd32: u = mk(OP_ASR, REG_R1, SRC_R1, SRC_R1, 6'd33, '0, 1'b0, 1'b0, 1'b0);
         6'd33: u = mk(OP_CHKZ, REG_R1, SRC_R1, SRC_R1, 6'd0, '0, 1'b0, 1'b0, 1'b0);
         6'd34: u = mk(OP_SUB, REG_R0, SRC_IMM, SRC_ADC, 6'd0, 21'd1048576, 1'b0, 1'b0, 1'b0);
         6'd35: u = mk(OP_SHL, REG_R0, SRC_R0, SRC_R0, 6'd31, '0, 1'b0, 1'b0, 1'b0);
         6'd36: u = mk(OP_SUB, REG_R0, SRC_R0, SRC_R2, 6'd0, '0, 1'b0, 1'b0, 1'b0);
         6'd37: u = mk(OP_MUL, REG_R0, SRC_R0, SRC_IMM, 6'd0, 21'd3125, 1'b0, 1'b0, 1'b0);
         6'd38: u = mk(OP_DIV, REG_R0, SRC_R0, SRC_R1, 6'd0, '0, 1'b0, 1'b0, 1'b0);
         6'd39: u = mk(OP_ASR, REG_R1, SRC_R0, SRC_R0, 6'd13, '0, 1'b0, 1'b0, 1'b0);
         6'd40: u = mk(OP_MUL, REG_R2, SRC_P9, SRC_R1, 6'd0, '0, 1'b0, 1'b0, 1'b0);
         6'd41: u = mk(OP_MUL, REG_R2, SRC_R2, SRC_R1, 6'd0, '0, 1'b0, 1'b0, 1'b0);
         6'd42: u = mk(OP_ASR, REG_R2, SRC_R2, SRC_R2, 6'd25, '0, 1'b0, 1'b0, 1'b0);
         6'd43: u = mk(OP_MUL, REG_R3, SRC_P8, SRC_R0, 6'd0, '0, 1'b0, 1'b0, 1'b0);
         6'd44: u = mk(OP_ASR, REG_R3, SRC_R3, SRC_R3, 6'd19, '0, 1'b0, 1'b0, 1'b0);
         6'd45: u = mk(OP_ADD, REG_R0, SRC_R0, SRC_R2, 6'd0, '0, 1'b0, 1'b0, 1'b0);
         6'd46: u = mk(OP_ADD, REG_R0, SRC_R0, SRC_R3, 6'd0, '0, 1'b0, 1'b0, 1'b0);
         6'd47: u = mk(OP_ASR, REG_R0, SRC_R0, SRC_R0, 6'd8, '0, 1'b0, 1'b0, 1'b0);
         6'd48: u = mk(OP_SHL, REG_R3, SRC_P7, SRC_P7, 6'd4, '0, 1'b0, 1'b0, 1'b0);
         6'd49: u = mk(OP_ADD, REG_R0, SRC_R0, SRC_R3, 6'd0, '0, 1'b0, 1'b0, 1'b1);
         default: u = mk(OP_NOP, REG_R0, SRC_R0, SRC_R0, 6'd0, '0, 1'b0, 1'b0, 1'b1);
      endcase
      return u;
   endfunction

endpackage

/* rtl/core/barometric_temp_pressure_compensation_unit.sv */
// One beat is handled at a time; a pressure reading ends early when its divisor is zero.
// The radix-2 divider and the shared 32x32 multiplier (three partial products per
// 64-bit product) set how long a pressure reading takes.
// A new beat is taken while the previous result still waits in the output register.
// Reset (synchronous, active high) clears trim registers and the fine temperature.
// ----------------------------------------------------------------------------
// Barometric temperature and pressure compensation unit
// Compensates raw temperature and pressure readings with programmable trim
// coefficients, using a microprogrammed controller over a shared datapath.
// ----------------------------------------------------------------------------
module barometric_temp_pressure_compensation_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  bpc_pkg::bpc_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output bpc_pkg::bpc_rsp_type rsp_data,
   input  logic                 csr_we,
   input  logic [2:0]           csr_addr,
   input  logic [31:0]          csr_wdata
);

   // The controller walks a fixed microprogram, one step per datapath
   // operation; multiplies and the divide hold the step until they finish.
   bpc_pkg::bpc_cmd_type  cmd;
   bpc_pkg::bpc_stat_type stat;

   bpc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_data.cmd),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // The datapath holds the trim registers, the kept fine temperature and
   // the output register that decouples the result side.
   bpc_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_data  (rsp_data)
   );

endmodule

/* rtl/core/bpc_datapath.sv */
// ----------------------------------------------------------------------------
// Compensation datapath
// Trim registers, working registers, shared 32x32 multiplier and a radix-2
// signed divider, driven one step at a time by the controller.
// ----------------------------------------------------------------------------
module bpc_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [2:0]           csr_addr,
   input  logic [31:0]          csr_wdata,
   input  bpc_pkg::bpc_req_type req_data,
   input  bpc_pkg::bpc_cmd_type cmd,
   output bpc_pkg::bpc_stat_type stat,
   output bpc_pkg::bpc_rsp_type rsp_data
);

   logic [15:0] t1_ff, t2_ff, t3_ff, p1_ff;
   logic [31:0] p23_ff, p45_ff, p67_ff, p89_ff;
   logic [31:0] fine_ff;
   logic [19:0] adc_ff;
   logic [63:0] r0_ff, r1_ff, r2_ff, r3_ff;
   logic [bpc_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic [63:0] macc_ff, macc_in;
   logic [63:0] rem_ff, rem_in, quo_ff, quo_in, dvs_ff, dvs_in;
   logic        neg_ff, neg_in;
   bpc_pkg::bpc_rsp_type rsp_ff;

   logic [63:0] src_a, src_b, opa, opb, alu_res, res;
   logic [31:0] ma, mb, mul_hi;
   logic [63:0] prod;
   logic [64:0] trial;
   logic        trial_ge;
   logic        done, wr;

   function automatic logic [63:0] sx16(input logic [15:0] v);
      return {{48{v[15]}}, v};
   endfunction

   function automatic logic [63:0] sx32(input logic [31:0] v);
      return {{32{v[31]}}, v};
   endfunction

   function automatic logic [63:0] pick(input bpc_pkg::bpc_src_type s,
                                        input logic [63:0] r0, input logic [63:0] r1,
                                        input logic [63:0] r2, input logic [63:0] r3,
                                        input logic [63:0] imm, input logic [63:0] adc,
                                        input logic [31:0] fine, input logic [15:0] t1,
                                        input logic [15:0] t2, input logic [15:0] t3,
                                        input logic [15:0] p1, input logic [31:0] p23,
                                        input logic [31:0] p45, input logic [31:0] p67,
                                        input logic [31:0] p89);
      logic [63:0] v;
      unique case (s)
         bpc_pkg::SRC_R0:   v = r0;
         bpc_pkg::SRC_R1:   v = r1;
         bpc_pkg::SRC_R2:   v = r2;
         bpc_pkg::SRC_R3:   v = r3;
         bpc_pkg::SRC_ADC:  v = adc;
         bpc_pkg::SRC_FINE: v = sx32(fine);
         bpc_pkg::SRC_IMM:  v = imm;
         bpc_pkg::SRC_T1:   v = {48'd0, t1};
         bpc_pkg::SRC_T2:   v = sx16(t2);
         bpc_pkg::SRC_T3:   v = sx16(t3);
         bpc_pkg::SRC_P1:   v = {48'd0, p1};
         bpc_pkg::SRC_P2:   v = sx16(p23[15:0]);
         bpc_pkg::SRC_P3:   v = sx16(p23[31:16]);
         bpc_pkg::SRC_P4:   v = sx16(p45[15:0]);
         bpc_pkg::SRC_P5:   v = sx16(p45[31:16]);
         bpc_pkg::SRC_P6:   v = sx16(p67[15:0]);
         bpc_pkg::SRC_P7:   v = sx16(p67[31:16]);
         bpc_pkg::SRC_P8:   v = sx16(p89[15:0]);
         bpc_pkg::SRC_P9:   v = sx16(p89[31:16]);
         default:           v = '0;
      endcase
      return v;
   endfunction

   always_comb begin
      src_a = pick(cmd.uop.src_a, r0_ff, r1_ff, r2_ff, r3_ff,
                   {{(64-bpc_pkg::IMM_W){1'b0}}, cmd.uop.imm}, {44'd0, adc_ff}, fine_ff,
                   t1_ff, t2_ff, t3_ff, p1_ff, p23_ff, p45_ff, p67_ff, p89_ff);
      src_b = pick(cmd.uop.src_b, r0_ff, r1_ff, r2_ff, r3_ff,
                   {{(64-bpc_pkg::IMM_W){1'b0}}, cmd.uop.imm}, {44'd0, adc_ff}, fine_ff,
                   t1_ff, t2_ff, t3_ff, p1_ff, p23_ff, p45_ff, p67_ff, p89_ff);
      // In 32-bit mode the operands are taken as signed 32-bit words.
      opa = cmd.uop.w32 ? sx32(src_a[31:0]) : src_a;
      opb = cmd.uop.w32 ? sx32(src_b[31:0]) : src_b;
   end

   // Low 64 bits of a 64x64 product from three 32x32 partial products.
   always_comb begin
      ma     = (cnt_ff == bpc_pkg::MUL_LAST) ? opa[63:32] : opa[31:0];
      mb     = (cnt_ff == 7'd1) ? opb[63:32] : opb[31:0];
      prod   = {32'd0, ma} * {32'd0, mb};
      mul_hi = macc_ff[63:32] + prod[31:0];
   end

   always_comb begin
      trial    = {rem_ff, quo_ff[63]};
      trial_ge = trial >= {1'b0, dvs_ff};
   end

   always_comb begin
      unique case (cmd.uop.op)
         bpc_pkg::OP_ADD: alu_res = opa + opb;
         bpc_pkg::OP_SUB: alu_res = opa - opb;
         bpc_pkg::OP_SHL: alu_res = opa << cmd.uop.shamt;
         bpc_pkg::OP_ASR: alu_res = $unsigned($signed(opa) >>> cmd.uop.shamt);
         bpc_pkg::OP_MUL: alu_res = {mul_hi, macc_ff[31:0]};
         bpc_pkg::OP_DIV: alu_res = neg_ff ? (64'd0 - quo_ff) : quo_ff;
         default:         alu_res = '0;
      endcase
      res = cmd.uop.w32 ? sx32(alu_res[31:0]) : alu_res;
   end

   always_comb begin
      unique case (cmd.uop.op)
         bpc_pkg::OP_MUL: done = cmd.go && (cnt_ff == bpc_pkg::MUL_LAST);
         bpc_pkg::OP_DIV: done = cmd.go && (cnt_ff == bpc_pkg::DIV_LAST);
         default:         done = cmd.go;
      endcase
      wr = done && (cmd.uop.op != bpc_pkg::OP_NOP) && (cmd.uop.op != bpc_pkg::OP_CHKZ);
      cnt_in = (cmd.go && !done) ? cnt_ff + 7'd1 : '0;
   end

   always_comb begin
      macc_in = macc_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      neg_in  = neg_ff;
      if (cmd.go && cmd.uop.op == bpc_pkg::OP_MUL) begin
         macc_in = (cnt_ff == 7'd0) ? prod : {mul_hi, macc_ff[31:0]};
      end
      if (cmd.go && cmd.uop.op == bpc_pkg::OP_DIV) begin
         if (cnt_ff == 7'd0) begin
            neg_in = opa[63] ^ opb[63];
            quo_in = opa[63] ? (64'd0 - opa) : opa;
            dvs_in = opb[63] ? (64'd0 - opb) : opb;
            rem_in = '0;
         end else if (cnt_ff != bpc_pkg::DIV_LAST) begin
            rem_in = trial_ge ? (trial[63:0] - dvs_ff) : trial[63:0];
            quo_in = {quo_ff[62:0], trial_ge};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t1_ff   <= '0;
         t2_ff   <= '0;
         t3_ff   <= '0;
         p1_ff   <= '0;
         p23_ff  <= '0;
         p45_ff  <= '0;
         p67_ff  <= '0;
         p89_ff  <= '0;
         fine_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (csr_we) begin
            unique case (csr_addr)
               bpc_pkg::CSR_TEMP_COEF_1:    t1_ff  <= csr_wdata[15:0];
               bpc_pkg::CSR_TEMP_COEF_2:    t2_ff  <= csr_wdata[15:0];
               bpc_pkg::CSR_TEMP_COEF_3:    t3_ff  <= csr_wdata[15:0];
               bpc_pkg::CSR_PRESS_COEF_1:   p1_ff  <= csr_wdata[15:0];
               bpc_pkg::CSR_PRESS_COEF_2_3: p23_ff <= csr_wdata;
               bpc_pkg::CSR_PRESS_COEF_4_5: p45_ff <= csr_wdata;
               bpc_pkg::CSR_PRESS_COEF_6_7: p67_ff <= csr_wdata;
               bpc_pkg::CSR_PRESS_COEF_8_9: p89_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (wr && cmd.uop.fine_wr) begin
            fine_ff <= res[31:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      macc_ff <= macc_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dvs_ff  <= dvs_in;
      neg_ff  <= neg_in;
      if (cmd.load_in) begin
         adc_ff <= req_data.raw_sample;
      end
      if (wr) begin
         unique case (cmd.uop.dst)
            bpc_pkg::REG_R0: r0_ff <= res;
            bpc_pkg::REG_R1: r1_ff <= res;
            bpc_pkg::REG_R2: r2_ff <= res;
            bpc_pkg::REG_R3: r3_ff <= res;
            default: ;
         endcase
      end
      if (cmd.out_wr) begin
         rsp_ff.kind              <= cmd.out_kind;
         rsp_ff.temperature_centi <= (cmd.out_kind == bpc_pkg::KIND_TEMP) ?
                                     $signed(r0_ff[31:0]) : 32'sd0;
         rsp_ff.pressure_q24_8    <= (cmd.out_kind == bpc_pkg::KIND_PRESS && !cmd.out_dz) ?
                                     r0_ff[31:0] : 32'd0;
         rsp_ff.divide_by_zero    <= cmd.out_dz;
      end
   end

   assign stat.done     = done;
   assign stat.div_zero = (r1_ff == 64'd0);
   assign rsp_data      = rsp_ff;

endmodule

/* rtl/core/bpc_ctrl.sv */
// ----------------------------------------------------------------------------
// Compensation controller
// Accepts a reading, steps the microprogram through the datapath and hands
// the result to the output register.
// ----------------------------------------------------------------------------
module bpc_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_cmd,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  bpc_pkg::bpc_stat_type stat,
   output bpc_pkg::bpc_cmd_type  cmd
);

   bpc_pkg::bpc_state_type state_ff, state_in;
   logic [bpc_pkg::PC_W-1:0] pc_ff, pc_in;
   logic kind_ff, kind_in, dz_ff, dz_in, rsp_valid_ff, rsp_valid_in;
   logic out_free;
   bpc_pkg::bpc_uop_type uop;

   assign uop      = bpc_pkg::uop_rom(pc_ff);
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      pc_in    = pc_ff;
      kind_in  = kind_ff;
      dz_in    = dz_ff;
      unique case (state_ff)
         bpc_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = bpc_pkg::ST_RUN;
               kind_in  = req_cmd;
               dz_in    = 1'b0;
               pc_in    = (req_cmd == bpc_pkg::KIND_PRESS) ? bpc_pkg::PC_PRESS
                                                           : bpc_pkg::PC_TEMP;
            end
         end
         bpc_pkg::ST_RUN: begin
            if (stat.done) begin
               if (uop.op == bpc_pkg::OP_CHKZ && stat.div_zero) begin
                  dz_in    = 1'b1;
                  state_in = bpc_pkg::ST_EMIT;
               end else if (uop.last) begin
                  state_in = bpc_pkg::ST_EMIT;
               end else begin
                  pc_in = pc_ff + 6'd1;
               end
            end
         end
         bpc_pkg::ST_EMIT: begin
            if (out_free) begin
               state_in = bpc_pkg::ST_IDLE;
            end
         end
         default: state_in = bpc_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd          = '0;
      cmd.uop      = uop;
      cmd.out_kind = kind_ff;
      cmd.out_dz   = dz_ff;
      req_ready    = 1'b0;
      unique case (state_ff)
         bpc_pkg::ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.load_in = req_valid;
         end
         bpc_pkg::ST_RUN:  cmd.go     = 1'b1;
         bpc_pkg::ST_EMIT: cmd.out_wr = out_free;
         default: ;
      endcase
      rsp_valid_in = cmd.out_wr || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bpc_pkg::ST_IDLE;
         pc_ff        <= '0;
         kind_ff      <= 1'b0;
         dz_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pc_ff        <= pc_in;
         kind_ff      <= kind_in;
         dz_ff        <= dz_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

/* rtl/core/bpc_checker.sv */
// ----------------------------------------------------------------------------
// Compensation port checker
// Watches the ports of the compensation unit for result consistency.
// ----------------------------------------------------------------------------
module bpc_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input bpc_pkg::bpc_rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result beat dropped or changed while stalled");

   a_temp_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind == bpc_pkg::KIND_TEMP |->
         rsp_data.pressure_q24_8 == 32'd0 && !rsp_data.divide_by_zero)
      else $error("temperature beat carries pressure fields");

   a_press_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind == bpc_pkg::KIND_PRESS |->
         rsp_data.temperature_centi == 32'sd0)
      else $error("pressure beat carries a temperature");

   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.divide_by_zero |-> rsp_data.pressure_q24_8 == 32'd0)
      else $error("zero divisor beat with nonzero pressure");

endmodule

bind barometric_temp_pressure_compensation_unit bpc_checker u_bpc_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// Barometric compensation unit testbench
// Drives temperature and pressure readings through the compensation unit under
// several trim settings and checks every result against a built-in predictor.
// ----------------------------------------------------------------------------
module tb;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int SETTLE_CYCLES  = 200;
   localparam int NUM_PHASES     = 6;
   localparam int ITEMS_PER_PHASE = 275;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   bpc_pkg::bpc_req_type req_data;
   logic                 rsp_valid;
   logic                 rsp_ready;
   bpc_pkg::bpc_rsp_type rsp_data;
   logic                 csr_we;
   logic [2:0]           csr_addr;
   logic [31:0]          csr_wdata;

   barometric_temp_pressure_compensation_unit DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata)
   );

   // Predictor copy of the trim registers and the kept fine temperature.
   logic [15:0] trim_t1, trim_t2, trim_t3, trim_p1;
   logic [31:0] trim_p23, trim_p45, trim_p67, trim_p89;
   logic [31:0] fine_temp;

   bpc_pkg::bpc_req_type reading_queue[$];
   bpc_pkg::bpc_rsp_type compensated_queue[$];
   int          mismatch_count;
   int          idle_cycles;
   bit          timed_out;
   bit          no_idling;
   int          req_gap;
   int          rsp_gap;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic logic [63:0] sext16(input logic [15:0] v);
      return {{48{v[15]}}, v};
   endfunction

   // Signed 64-bit quotient truncated toward zero, with two's complement wrap.
   function automatic logic [63:0] quot64(input logic [63:0] n, input logic [63:0] d);
      logic [63:0] an, ad, q;
      an = n[63] ? -n : n;
      ad = d[63] ? -d : d;
      q  = an / ad;
      return (n[63] != d[63]) ? -q : q;
   endfunction

   // Computes the expected result of one reading and updates the fine temperature.
   function automatic bpc_pkg::bpc_rsp_type compensate(input bpc_pkg::bpc_req_type rd);
      bpc_pkg::bpc_rsp_type r;
      logic [31:0] adc, t1, t2, t3, a, d, v32;
      logic signed [63:0] v1, v2, p, h, p1, p2, p3, p4, p5, p6, p7, p8, p9;
      r   = '0;
      adc = {12'd0, rd.raw_sample};
      if (rd.cmd == bpc_pkg::KIND_TEMP) begin
         t1 = {16'd0, trim_t1};
         t2 = {{16{trim_t2[15]}}, trim_t2};
         t3 = {{16{trim_t3[15]}}, trim_t3};
         a  = ((adc >> 3) - (t1 << 1)) * t2;
         d  = (adc >> 4) - t1;
         v32 = d * d;
         v32 = $signed(v32) >>> 12;
         v32 = v32 * t3;
         v32 = $signed(v32) >>> 14;
         a   = $signed(a) >>> 11;
         fine_temp = a + v32;
         v32 = fine_temp * 32'd5 + 32'd128;
         r.kind = bpc_pkg::KIND_TEMP;
         r.temperature_centi = $signed(v32) >>> 8;
      end else begin
         p1 = {48'd0, trim_p1};
         p2 = sext16(trim_p23[15:0]);  p3 = sext16(trim_p23[31:16]);
         p4 = sext16(trim_p45[15:0]);  p5 = sext16(trim_p45[31:16]);
         p6 = sext16(trim_p67[15:0]);  p7 = sext16(trim_p67[31:16]);
         p8 = sext16(trim_p89[15:0]);  p9 = sext16(trim_p89[31:16]);
         r.kind = bpc_pkg::KIND_PRESS;
         v1 = {{32{fine_temp[31]}}, fine_temp} - 64'sd128000;
         v2 = v1 * v1 * p6;
         v2 = v2 + ((v1 * p5) <<< 17);
         v2 = v2 + (p4 <<< 35);
         v1 = ((v1 * v1 * p3) >>> 8) + ((v1 * p2) <<< 12);
         v1 = (((64'sd1 <<< 47) + v1) * p1) >>> 33;
         if (v1 == 0) begin
            r.divide_by_zero = 1'b1;
         end else begin
            p = 64'sd1048576 - $signed({44'd0, rd.raw_sample});
            p = quot64(((p <<< 31) - v2) * 64'sd3125, v1);
            h = p >>> 13;
            v1 = (p9 * h * h) >>> 25;
            v2 = (p8 * p) >>> 19;
            p = ((p + v1 + v2) >>> 8) + (p7 <<< 4);
            r.pressure_q24_8 = p[31:0];
         end
      end
      return r;
   endfunction

   // Request driver: presents queued readings with random bursts of idle cycles.
   // An accepted reading leaves the queue here, so the next one is at its head.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_gap   <= 0;
      end else if (!req_valid || req_ready) begin
         if (req_valid && reading_queue.size() > 0) begin
            compensated_queue.push_back(compensate(reading_queue.pop_front()));
         end
         if (req_gap > 0) begin
            req_gap   <= req_gap - 1;
            req_valid <= 1'b0;
         end else if (!no_idling && $urandom_range(0, 5) == 0) begin
            req_gap   <= $urandom_range(0, 3);
            req_valid <= 1'b0;
         end else if (reading_queue.size() > 0) begin
            req_valid <= 1'b1;
            req_data  <= reading_queue[0];
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Response monitor: checks each accepted beat and toggles back-pressure.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_gap   <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (compensated_queue.size() == 0) begin
               mismatch_count <= mismatch_count + 1;
               if (mismatch_count < 10)
                  $display("unexpected result beat %p", rsp_data);
            end else if (rsp_data !== compensated_queue[0]) begin
               mismatch_count <= mismatch_count + 1;
               if (mismatch_count < 10)
                  $display("mismatch: expected %p actual %p", compensated_queue[0], rsp_data);
               void'(compensated_queue.pop_front());
            end else begin
               void'(compensated_queue.pop_front());
            end
         end
         if (rsp_gap > 0) begin
            rsp_gap   <= rsp_gap - 1;
            rsp_ready <= 1'b0;
         end else if (!no_idling && $urandom_range(0, 5) == 0) begin
            rsp_gap   <= $urandom_range(0, 3);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Watchdog on cycles in which no beat moves on either channel.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (reading_queue.size() == 0 && compensated_queue.size() == 0)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("barometric_temp_pressure_compensation_unit test failed");
            $finish;
         end
      end
   end

   // Writes one trim register on the port and in the predictor.
   task automatic write_trim(input logic [2:0] idx, input logic [31:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      case (idx)
         bpc_pkg::CSR_TEMP_COEF_1:    trim_t1  = val[15:0];
         bpc_pkg::CSR_TEMP_COEF_2:    trim_t2  = val[15:0];
         bpc_pkg::CSR_TEMP_COEF_3:    trim_t3  = val[15:0];
         bpc_pkg::CSR_PRESS_COEF_1:   trim_p1  = val[15:0];
         bpc_pkg::CSR_PRESS_COEF_2_3: trim_p23 = val;
         bpc_pkg::CSR_PRESS_COEF_4_5: trim_p45 = val;
         bpc_pkg::CSR_PRESS_COEF_6_7: trim_p67 = val;
         default:                     trim_p89 = val;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic queue_reading(input logic cmd, input logic [19:0] raw);
      bpc_pkg::bpc_req_type rd;
      rd.cmd        = cmd;
      rd.raw_sample = raw;
      reading_queue.push_back(rd);
   endtask

   // Waits until every queued reading is accepted and every result has arrived.
   task automatic drain;
      while (reading_queue.size() > 0 || compensated_queue.size() > 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Loads one trim set; mode 0 is typical, 1 all zero, 2 all ones, 3 extremes, else random.
   task automatic load_trims(input int mode);
      logic [31:0] v;
      for (int i = 0; i < 8; i++) begin
         case (mode)
            0: v = (i == 0) ? 32'd27504 : (i == 1) ? 32'd26435 : (i == 2) ? 32'hFC18 :
                   (i == 3) ? 32'd36477 : (i == 4) ? {16'd3024, 16'hD67F} :
                   (i == 5) ? {16'd140, 16'd2855} : (i == 6) ? {16'd15500, 16'hFFF9} :
                   {16'd6000, 16'hD800};
            1: v = 32'd0;
            2: v = 32'hFFFF_FFFF;
            3: v = (i % 2) ? 32'h8000_7FFF : 32'h7FFF_8000;
            default: v = $urandom;
         endcase
         write_trim(i[2:0], v);
      end
   endtask

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_data       = '0;
      rsp_ready      = 1'b0;
      csr_we         = 1'b0;
      csr_addr       = '0;
      csr_wdata      = '0;
      mismatch_count = 0;
      idle_cycles    = 0;
      no_idling      = 1'b0;
      {trim_t1, trim_t2, trim_t3, trim_p1} = '0;
      {trim_p23, trim_p45, trim_p67, trim_p89} = '0;
      fine_temp = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // A pressure reading before any temperature uses the reset fine temperature,
      // and with zero trims the divisor is zero.
      queue_reading(bpc_pkg::KIND_PRESS, 20'd0);
      queue_reading(bpc_pkg::KIND_TEMP, 20'hFFFFF);
      queue_reading(bpc_pkg::KIND_PRESS, 20'hFFFFF);
      drain();

      // Directed part: field extremes under typical and extreme trim sets.
      load_trims(0);
      queue_reading(bpc_pkg::KIND_PRESS, 20'd415148);
      queue_reading(bpc_pkg::KIND_TEMP, 20'd519888);
      queue_reading(bpc_pkg::KIND_PRESS, 20'd415148);
      queue_reading(bpc_pkg::KIND_PRESS, 20'd415148);
      queue_reading(bpc_pkg::KIND_TEMP, 20'd0);
      queue_reading(bpc_pkg::KIND_PRESS, 20'd0);
      queue_reading(bpc_pkg::KIND_TEMP, 20'hFFFFF);
      queue_reading(bpc_pkg::KIND_PRESS, 20'hFFFFF);
      queue_reading(bpc_pkg::KIND_TEMP, 20'h55555);
      queue_reading(bpc_pkg::KIND_PRESS, 20'hAAAAA);
      drain();
      for (int m = 2; m <= 3; m++) begin
         load_trims(m);
         queue_reading(bpc_pkg::KIND_TEMP, 20'h00000);
         queue_reading(bpc_pkg::KIND_PRESS, 20'hFFFFF);
         queue_reading(bpc_pkg::KIND_TEMP, 20'hFFFFF);
         queue_reading(bpc_pkg::KIND_PRESS, 20'h00000);
         drain();
      end

      // Random phases: mostly temperature then pressure pairs with random content.
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         load_trims((ph == 0) ? 0 : (ph == 1) ? 1 : 4);
         if (ph == NUM_PHASES - 1) no_idling = 1'b1;
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if ($urandom_range(0, 3) == 0)
               queue_reading(1'($urandom_range(0, 1)), 20'($urandom));
            else
               queue_reading(1'(n % 2), $urandom_range(0, 3) == 0 ?
                                        20'(20'hFFFFF * $urandom_range(0, 1)) :
                                        20'($urandom));
         end
         drain();
      end

      if (mismatch_count == 0) begin
         $display("barometric_temp_pressure_compensation_unit test passed");
      end else begin
         $display("barometric_temp_pressure_compensation_unit test failed");
      end
      $finish;
   end

endmodule
